// ===== sv/mfps_pkg.sv =====
package mfps_pkg;

  localparam int CODE_W         = 5;
  localparam int MAX_FEATURES   = 8;
  localparam int TABLE_VALUE_W  = 16;
  localparam int SCORE_W        = 19;
  localparam int CODES_W        = CODE_W * MAX_FEATURES;
  localparam int FEAT_SEL_W     = 3;
  localparam int COUNT_W        = 4;

  localparam int FEATURES_DEF   = 8;
  localparam int ALPHA_MAX_DEF  = 32;
  localparam int VALUE_BITS_DEF = 16;

  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;

  // register index taken from paddr[2]
  localparam logic REG_FEATURE_COUNT = 1'b0;
  localparam logic [COUNT_W-1:0] FEATURE_COUNT_RESET = 4'd8;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_SCORE = 1'b1;

  // request from the top level to one lane
  typedef struct packed {
    logic              wr;     // store value at (row, col)
    logic              rd;     // read (row, col) for a cell
    logic              use_f;  // feature counts toward this cell
    logic [CODE_W-1:0] row;
    logic [CODE_W-1:0] col;
  } lane_req_t;

  // cell held behind the table read
  typedef struct packed {
    logic valid;
    logic row_end;
    logic matrix_end;
  } pipe_ctl_t;

endpackage

// ===== sv/mfps_in_if.sv =====
interface mfps_in_if;
  import mfps_pkg::*;

  logic                            valid;
  logic                            ready;
  logic                            mode;
  logic [FEAT_SEL_W-1:0]           table_feature;
  logic [CODE_W-1:0]               table_row;
  logic [CODE_W-1:0]               table_col;
  logic signed [TABLE_VALUE_W-1:0] table_value;
  logic [CODES_W-1:0]              codes_a;
  logic [CODES_W-1:0]              codes_b;
  logic                            row_end;
  logic                            matrix_end;

  modport source (
    output valid, mode, table_feature, table_row, table_col, table_value,
           codes_a, codes_b, row_end, matrix_end,
    input  ready
  );

  modport sink (
    input  valid, mode, table_feature, table_row, table_col, table_value,
           codes_a, codes_b, row_end, matrix_end,
    output ready
  );

endinterface

// ===== sv/mfps_out_if.sv =====
interface mfps_out_if;
  import mfps_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] score;
  logic                      last_in_row;
  logic                      last_of_matrix;

  modport source (
    output valid, score, last_in_row, last_of_matrix,
    input  ready
  );

  modport sink (
    input  valid, score, last_in_row, last_of_matrix,
    output ready
  );

endinterface

// ===== sv/multi_feature_pair_score_top.sv =====
// One request is taken per cycle, table loads and cell scores alike, unless the read stage is held
// by a stalled output register. A cell's score passes through the registered read of the per-feature
// score tables, then the adder tree into the output register. Each of the FEATURES lanes owns
// a RAM of ALPHA_MAX*ALPHA_MAX entries; a load writes one entry of one lane, a cell reads one
// entry in every lane in the same cycle. Entries are undefined until loaded, and scoring a cell
// that touches an unloaded entry gives an unspecified score. feature_count (paddr 0) sets how
// many features enter the sum; zero counts as one, larger values saturate to FEATURES.
module multi_feature_pair_score_top #(
  parameter int FEATURES   = mfps_pkg::FEATURES_DEF,
  parameter int ALPHA_MAX  = mfps_pkg::ALPHA_MAX_DEF,
  parameter int VALUE_BITS = mfps_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mfps_in_if.sink                         in_ch,
  mfps_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [mfps_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [mfps_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [mfps_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import mfps_pkg::*;

  logic [COUNT_W-1:0] feature_count_r;
  logic [COUNT_W-1:0] feature_count_nxt;
  logic               cfg_wr;

  logic               in_acc;
  logic               take;
  logic               s1_valid_r;
  logic               s1_valid_nxt;
  logic               s1_row_end_r;
  logic               s1_matrix_end_r;
  pipe_ctl_t          ctl;

  logic signed [VALUE_BITS-1:0]        wr_value;
  logic [FEATURES-1:0][VALUE_BITS-1:0] lane_value;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign feature_count_nxt = (cfg_wr && cfg_paddr[2] == REG_FEATURE_COUNT) ?
                             cfg_pwdata[COUNT_W-1:0] : feature_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feature_count_r <= FEATURE_COUNT_RESET;
    end else begin
      feature_count_r <= feature_count_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_FEATURE_COUNT) ?
                      CFG_DATA_W'(feature_count_r) : '0;

  // stored value saturates to VALUE_BITS
  if (VALUE_BITS >= TABLE_VALUE_W) begin : g_value_ext
    assign wr_value = VALUE_BITS'(in_ch.table_value);
  end else begin : g_value_clamp
    logic value_ovf;
    assign value_ovf = (in_ch.table_value[TABLE_VALUE_W-1:VALUE_BITS-1] != '0) &&
                       (in_ch.table_value[TABLE_VALUE_W-1:VALUE_BITS-1] != '1);
    assign wr_value = !value_ovf ? in_ch.table_value[VALUE_BITS-1:0] :
                      (in_ch.table_value[TABLE_VALUE_W-1] ?
                       {1'b1, {(VALUE_BITS-1){1'b0}}} : {1'b0, {(VALUE_BITS-1){1'b1}}});
  end

  // hold the request while the read stage is stuck behind the output
  assign in_ch.ready = !s1_valid_r || take;
  assign in_acc = in_ch.valid && in_ch.ready;

  for (genvar f = 0; f < FEATURES; f++) begin : g_lane
    lane_req_t req;

    always_comb begin
      req.wr    = in_acc && (in_ch.mode == MODE_WRITE) &&
                  (in_ch.table_feature == FEAT_SEL_W'(f));
      req.rd    = in_acc && (in_ch.mode == MODE_SCORE);
      req.use_f = (f == 0) || (COUNT_W'(f) < feature_count_r);
      if (in_ch.mode == MODE_WRITE) begin
        req.row = in_ch.table_row;
        req.col = in_ch.table_col;
      end else begin
        req.row = in_ch.codes_a[CODE_W*f +: CODE_W];
        req.col = in_ch.codes_b[CODE_W*f +: CODE_W];
      end
    end

    mfps_lane #(
      .ALPHA_MAX  (ALPHA_MAX),
      .VALUE_BITS (VALUE_BITS)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .req      (req),
      .wr_value (wr_value),
      .value    (lane_value[f])
    );
  end

  // read stage: advance a cell when the merge stage takes it
  always_comb begin
    if (in_acc && in_ch.mode == MODE_SCORE) begin
      s1_valid_nxt = 1'b1;
    end else if (take) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.mode == MODE_SCORE) begin
      s1_row_end_r    <= in_ch.row_end;
      s1_matrix_end_r <= in_ch.matrix_end;
    end
  end

  assign ctl.valid      = s1_valid_r;
  assign ctl.row_end    = s1_row_end_r;
  assign ctl.matrix_end = s1_matrix_end_r;

  mfps_merge #(
    .FEATURES   (FEATURES),
    .VALUE_BITS (VALUE_BITS)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .lane_value (lane_value),
    .ctl        (ctl),
    .take       (take),
    .out_ch     (out_ch)
  );

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with an empty output register");

  a_score_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.mode == MODE_SCORE) |=> s1_valid_r)
    else $error("scored cell lost at the read stage");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.mode == MODE_WRITE && !s1_valid_r) |=> !s1_valid_r)
    else $error("table load produced a cell");

  a_read_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !take) |=> (s1_valid_r && $stable(s1_row_end_r) &&
                               $stable(s1_matrix_end_r)))
    else $error("stalled cell changed in the read stage");
`endif

endmodule

// ===== sv/mfps_ram.sv =====
module mfps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/mfps_lane.sv =====
module mfps_lane #(
  parameter int ALPHA_MAX  = 32,
  parameter int VALUE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mfps_pkg::lane_req_t          req,
  input  logic signed [VALUE_BITS-1:0] wr_value,
  output logic signed [VALUE_BITS-1:0] value
);
  import mfps_pkg::*;

  localparam int DEPTH  = ALPHA_MAX * ALPHA_MAX;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(ALPHA_MAX);

  logic              in_range;
  logic [ADDR_W-1:0] addr;
  logic [VALUE_BITS-1:0] rd_data;
  logic              use_r;
  logic              use_nxt;

  assign in_range = ({1'b0, req.row} < (CODE_W + 1)'(ALPHA_MAX)) &&
                    ({1'b0, req.col} < (CODE_W + 1)'(ALPHA_MAX));

  assign addr = ADDR_W'(req.row[IDX_W-1:0]) * ADDR_W'(ALPHA_MAX) +
                ADDR_W'(req.col[IDX_W-1:0]);

  mfps_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (req.wr && in_range),
    .waddr (addr),
    .wdata (wr_value),
    .re    (req.rd),
    .raddr (addr),
    .rdata (rd_data)
  );

  // drop features past the count and codes outside the alphabet
  assign use_nxt = req.rd ? (req.use_f && in_range) : use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_r <= 1'b0;
    end else begin
      use_r <= use_nxt;
    end
  end

  assign value = use_r ? signed'(rd_data) : '0;

endmodule

// ===== sv/mfps_merge.sv =====
module mfps_merge #(
  parameter int FEATURES   = 8,
  parameter int VALUE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [FEATURES-1:0][VALUE_BITS-1:0] lane_value,
  input  mfps_pkg::pipe_ctl_t                 ctl,
  output logic                                take,
  mfps_out_if.source                          out_ch
);
  import mfps_pkg::*;

  localparam int SUM_W = VALUE_BITS + $clog2(FEATURES) + 1;

  logic signed [SUM_W-1:0]   sum;
  logic signed [SCORE_W-1:0] score_sat;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic signed [SCORE_W-1:0] score_r;
  logic                      last_in_row_r;
  logic                      last_of_matrix_r;

  always_comb begin
    sum = '0;
    for (int f = 0; f < FEATURES; f++) begin
      sum = sum + SUM_W'(signed'(lane_value[f]));
    end
  end

  if (SUM_W > SCORE_W) begin : g_clamp
    logic overflow;
    assign overflow = (sum[SUM_W-1:SCORE_W-1] != '0) && (sum[SUM_W-1:SCORE_W-1] != '1);
    assign score_sat = !overflow ? sum[SCORE_W-1:0] :
                       (sum[SUM_W-1] ? {1'b1, {(SCORE_W-1){1'b0}}} :
                                       {1'b0, {(SCORE_W-1){1'b1}}});
  end else begin : g_extend
    assign score_sat = SCORE_W'(sum);
  end

  // output register is free or drains this cycle
  assign take = !out_valid_r || out_ch.ready;
  assign out_valid_nxt = take ? ctl.valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && ctl.valid) begin
      score_r          <= score_sat;
      last_in_row_r    <= ctl.row_end;
      last_of_matrix_r <= ctl.matrix_end;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.score          = score_r;
  assign out_ch.last_in_row    = last_in_row_r;
  assign out_ch.last_of_matrix = last_of_matrix_r;

endmodule

// ===== test/tb_multi_feature_pair_score_top.sv =====
`timescale 1ns / 1ps

module tb_multi_feature_pair_score_top;
  import mfps_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int ITEM_TARGET   = 1900;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 6;
  localparam int ALPHA         = ALPHA_MAX_DEF;
  localparam int SCORE_MAX     = (1 << (SCORE_W - 1)) - 1;
  localparam int SCORE_MIN     = -(1 << (SCORE_W - 1));
  localparam logic [CFG_ADDR_W-1:0] FEATURE_COUNT_ADDR = {REG_FEATURE_COUNT, 2'b00};

  typedef struct {
    logic signed [SCORE_W-1:0] score;
    logic                      last_in_row;
    logic                      last_of_matrix;
  } cell_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  mfps_in_if  in_ch ();
  mfps_out_if out_ch ();

  multi_feature_pair_score_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // shadow of the score tables and of the feature count
  logic signed [TABLE_VALUE_W-1:0] score_entry [MAX_FEATURES][ALPHA][ALPHA];
  bit                              entry_loaded [MAX_FEATURES][ALPHA][ALPHA];
  int                              loaded_cells [MAX_FEATURES][$];
  logic [COUNT_W-1:0]              feature_count_cfg = FEATURE_COUNT_RESET;

  cell_result_t pending_scores[$];
  int errors         = 0;
  int items_sent     = 0;
  int cycles         = 0;
  int src_gap_pct    = 0;
  int sink_stall_pct = 0;
  int sink_hold      = 0;

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic cell_result_t predict_cell(logic [CODES_W-1:0] codes_a,
                                                logic [CODES_W-1:0] codes_b,
                                                logic row_end, logic matrix_end);
    cell_result_t res;
    int n;
    int acc;
    logic [CODE_W-1:0] ca;
    logic [CODE_W-1:0] cb;
    n = (feature_count_cfg == '0) ? 1 : int'(feature_count_cfg);
    if (n > FEATURES_DEF) n = FEATURES_DEF;
    acc = 0;
    for (int f = 0; f < n; f++) begin
      ca = codes_a[f*CODE_W +: CODE_W];
      cb = codes_b[f*CODE_W +: CODE_W];
      if (ca < ALPHA && cb < ALPHA) acc += int'(score_entry[f][ca][cb]);
    end
    if (acc > SCORE_MAX) acc = SCORE_MAX;
    else if (acc < SCORE_MIN) acc = SCORE_MIN;
    res.score          = acc[SCORE_W-1:0];
    res.last_in_row    = row_end;
    res.last_of_matrix = matrix_end;
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin : check_results
    cell_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_scores.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual score %0d", $time,
                 out_ch.score);
      end else begin
        want = pending_scores.pop_front();
        if (out_ch.score !== want.score) begin
          errors++;
          $display("%0t: score mismatch: expected %0d, actual %0d", $time, want.score,
                   out_ch.score);
        end
        if (out_ch.last_in_row !== want.last_in_row) begin
          errors++;
          $display("%0t: last_in_row mismatch: expected %b, actual %b", $time,
                   want.last_in_row, out_ch.last_in_row);
        end
        if (out_ch.last_of_matrix !== want.last_of_matrix) begin
          errors++;
          $display("%0t: last_of_matrix mismatch: expected %b, actual %b", $time,
                   want.last_of_matrix, out_ch.last_of_matrix);
        end
      end
    end
  end

  // result backpressure: mostly short stalls, now and then a long one
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      out_ch.ready = 1'b0;
      sink_hold--;
    end else if ($urandom_range(0, 99) < sink_stall_pct) begin
      out_ch.ready = 1'b0;
      sink_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  task automatic send_request(logic mode, logic [FEAT_SEL_W-1:0] feat,
                              logic [CODE_W-1:0] row, logic [CODE_W-1:0] col,
                              logic signed [TABLE_VALUE_W-1:0] value,
                              logic [CODES_W-1:0] codes_a, logic [CODES_W-1:0] codes_b,
                              logic row_end, logic matrix_end);
    @(negedge clk);
    in_ch.valid         = 1'b1;
    in_ch.mode          = mode;
    in_ch.table_feature = feat;
    in_ch.table_row     = row;
    in_ch.table_col     = col;
    in_ch.table_value   = value;
    in_ch.codes_a       = codes_a;
    in_ch.codes_b       = codes_b;
    in_ch.row_end       = row_end;
    in_ch.matrix_end    = matrix_end;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (mode == MODE_WRITE) begin
      if (feat < FEATURES_DEF && row < ALPHA && col < ALPHA) begin
        score_entry[feat][row][col] = value;
        if (!entry_loaded[feat][row][col]) begin
          entry_loaded[feat][row][col] = 1'b1;
          loaded_cells[feat] = {loaded_cells[feat], int'(row) * ALPHA + int'(col)};
        end
      end
    end else begin
      pending_scores = {pending_scores, predict_cell(codes_a, codes_b, row_end, matrix_end)};
    end
  endtask

  task automatic pace_source();
    int len;
    if ($urandom_range(0, 99) >= src_gap_pct) return;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 2);
    @(negedge clk);
    in_ch.valid = 1'b0;
    repeat (len - 1) @(negedge clk);
  endtask

  // drop the request and hold until every score is back
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // marks and codes are noise on a table load
  task automatic load_entry(logic [FEAT_SEL_W-1:0] feat, logic [CODE_W-1:0] row,
                            logic [CODE_W-1:0] col, logic signed [TABLE_VALUE_W-1:0] value);
    send_request(MODE_WRITE, feat, row, col, value, CODES_W'({$urandom, $urandom}),
                 CODES_W'({$urandom, $urandom}), 1'($urandom), 1'($urandom));
    pace_source();
  endtask

  task automatic score_cell(logic [CODES_W-1:0] codes_a, logic [CODES_W-1:0] codes_b,
                            logic row_end, logic matrix_end);
    send_request(MODE_SCORE, FEAT_SEL_W'($urandom), CODE_W'($urandom), CODE_W'($urandom),
                 TABLE_VALUE_W'($urandom), codes_a, codes_b, row_end, matrix_end);
    pace_source();
  endtask

  task automatic load_random_entry();
    logic signed [TABLE_VALUE_W-1:0] value;
    case ($urandom_range(0, 9))
      0:       value = 16'sh7fff;
      1:       value = 16'sh8000;
      default: value = TABLE_VALUE_W'($urandom);
    endcase
    load_entry(FEAT_SEL_W'($urandom), CODE_W'($urandom), CODE_W'($urandom), value);
  endtask

  // every feature's code pair points at a loaded entry
  task automatic pick_loaded_codes(output logic [CODES_W-1:0] codes_a,
                                   output logic [CODES_W-1:0] codes_b);
    int rc;
    for (int f = 0; f < MAX_FEATURES; f++) begin
      rc = loaded_cells[f][$urandom_range(0, loaded_cells[f].size() - 1)];
      codes_a[f*CODE_W +: CODE_W] = CODE_W'(rc / ALPHA);
      codes_b[f*CODE_W +: CODE_W] = CODE_W'(rc % ALPHA);
    end
  endtask

  task automatic cfg_access(logic write, logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = write;
    cfg_paddr   = FEATURE_COUNT_ADDR;
    cfg_pwdata  = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic check_count_readback(logic [COUNT_W-1:0] want);
    logic [CFG_DATA_W-1:0] rdata;
    cfg_access(1'b0, '0, rdata);
    if (rdata !== CFG_DATA_W'(want)) begin
      errors++;
      $display("%0t: feature_count readback mismatch: expected %0d, actual %0d", $time,
               want, rdata);
    end
  endtask

  // upper data bits are random and must be dropped
  task automatic set_feature_count(logic [COUNT_W-1:0] count);
    logic [CFG_DATA_W-1:0] wdata;
    logic [CFG_DATA_W-1:0] unused;
    wdata = $urandom;
    wdata[COUNT_W-1:0] = count;
    cfg_access(1'b1, wdata, unused);
    feature_count_cfg = count;
    check_count_readback(count);
  endtask

  task automatic score_matrix();
    int rows;
    int cols;
    bit noisy;
    logic [CODES_W-1:0] codes_a;
    logic [CODES_W-1:0] codes_b;
    rows  = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 5);
    cols  = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 6);
    noisy = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < rows; i++) begin
      for (int j = 0; j < cols; j++) begin
        // table update in the middle of a matrix
        if ($urandom_range(0, 19) == 0) load_random_entry();
        pick_loaded_codes(codes_a, codes_b);
        if (noisy)
          score_cell(codes_a, codes_b, 1'($urandom), 1'($urandom));
        else
          score_cell(codes_a, codes_b, j == cols - 1, i == rows - 1 && j == cols - 1);
      end
    end
  endtask

  task automatic test_count_reset();
    check_count_readback(FEATURE_COUNT_RESET);
  endtask

  // full-scale entries give the largest and smallest possible sums at the reset count
  task automatic test_entry_extremes();
    logic [CODES_W-1:0] all_low;
    logic [CODES_W-1:0] all_high;
    logic [CODES_W-1:0] split;
    all_low  = '0;
    all_high = '1;
    for (int f = 0; f < MAX_FEATURES; f++)
      split[f*CODE_W +: CODE_W] = f[0] ? CODE_W'(ALPHA - 1) : '0;
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    for (int f = 0; f < FEATURES_DEF; f++) begin
      load_entry(FEAT_SEL_W'(f), '0, '0, 16'sh7fff);
      load_entry(FEAT_SEL_W'(f), CODE_W'(ALPHA - 1), CODE_W'(ALPHA - 1), 16'sh8000);
    end
    score_cell(all_low, all_low, 1'b0, 1'b0);
    score_cell(all_high, all_high, 1'b1, 1'b0);
    score_cell(split, split, 1'b1, 1'b1);
    load_entry('0, '0, '0, '0);
    score_cell(all_low, all_low, 1'b0, 1'b1);
    score_cell(split, split, 1'b1, 1'b0);
    wait_drained();
  endtask

  task automatic test_scored_matrices();
    int phase;
    int phase_end;
    logic [COUNT_W-1:0] count;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_drained();
      case (phase)
        0:       count = '0;
        1:       count = COUNT_W'(1);
        2:       count = '1;
        3:       count = COUNT_W'(FEATURES_DEF + 1);
        4:       count = COUNT_W'(FEATURES_DEF);
        default: count = COUNT_W'($urandom);
      endcase
      set_feature_count(count);
      case (phase)
        0: begin
          src_gap_pct    = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_gap_pct    = 40;
          sink_stall_pct = 30;
        end
        default: begin
          src_gap_pct    = 20 * $urandom_range(0, 2);
          sink_stall_pct = 15 * $urandom_range(0, 2);
        end
      endcase
      repeat ($urandom_range(20, 50)) load_random_entry();
      phase_end = items_sent + 150;
      while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
        score_matrix();
        if ($urandom_range(0, 24) == 0) wait_drained();
      end
      phase++;
    end
    wait_drained();
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.mode          = MODE_WRITE;
    in_ch.table_feature = '0;
    in_ch.table_row     = '0;
    in_ch.table_col     = '0;
    in_ch.table_value   = '0;
    in_ch.codes_a       = '0;
    in_ch.codes_b       = '0;
    in_ch.row_end       = 1'b0;
    in_ch.matrix_end    = 1'b0;
    out_ch.ready        = 1'b1;
    cfg_psel            = 1'b0;
    cfg_penable         = 1'b0;
    cfg_pwrite          = 1'b0;
    cfg_paddr           = '0;
    cfg_pwdata          = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_count_reset();
    test_entry_extremes();
    test_scored_matrices();

    if (errors == 0 && pending_scores.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
